>>> hw/rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg: shared definitions of the partition allocator
// Request and status codes, default sizes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned FreeEntriesDef = 64;
  localparam int unsigned UsedEntriesDef = 64;
  localparam int unsigned AddrBitsDef    = 16;
  localparam int unsigned JobBitsDef     = 8;

  localparam int unsigned StatusBits = 3;

  // Request codes.
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_ALLOC   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // Fit rules; the fourth code behaves as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Result status codes.
  localparam logic [StatusBits-1:0] ST_OK      = 3'd0;
  localparam logic [StatusBits-1:0] ST_NO_FIT  = 3'd1;
  localparam logic [StatusBits-1:0] ST_NO_JOB  = 3'd2;
  localparam logic [StatusBits-1:0] ST_FULL    = 3'd3;
  localparam logic [StatusBits-1:0] ST_ZERO_SZ = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_H_READ_IDX,
    OP_H_READ_SHDN,
    OP_H_READ_SHUP,
    OP_INS_EVAL,
    OP_SHUP_START,
    OP_SHUP_WRITE,
    OP_INS_WRITE,
    OP_SHDN_WRITE,
    OP_H_DROP,
    OP_PICK_EVAL,
    OP_GRANT,
    OP_SPLIT,
    OP_G_READ,
    OP_G_EVAL,
    OP_G_FOUND,
    OP_ADJ_EVAL,
    OP_MERGE_BOTH,
    OP_MERGE_PRED,
    OP_MERGE_SUCC,
    OP_INS_START,
    OP_G_READ_NEXT,
    OP_G_SHIFT_WRITE,
    OP_G_DROP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e                op;
    logic [StatusBits-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       h_full;
    logic       g_full;
    logic       h_idx_end;
    logic       ins_le;
    logic       h_sh_at_pos;
    logic       h_rem_end;
    logic       pick_ok;
    logic       exact;
    logic       g_idx_end;
    logic       g_rem_end;
    logic       g_found;
    logic       pred_v;
    logic       succ_v;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator: first, best and worst fit region allocator
// Keeps a free-region table and a grant table and serves load, allocate and
// release requests one at a time.
// ----------------------------------------------------------------------------
// The block takes one request item at a time and returns exactly one result
// item for it. A load inserts a free region behind all regions with a lower or
// equal start. An allocate scans every free region for the first, best or
// worst fit, ties going to the lowest start, records the grant, and then
// either shrinks the chosen region or removes it on an exact fit. A release
// finds the job's most recent grant, merges it with a free region ending at
// its start and one starting at its end, or inserts it, and drops the grant.
// Both tables sit in single-port-read memories with registered read data, so
// every scanned entry and every entry moved by an insert or a removal takes
// a read step followed by an evaluate or write step. The final step of a
// request waits while the previous result is still stalled in the output
// register.
// Requests are refused while the sequencer is busy; a finished result waits
// in the output register while the next request is already accepted. Table
// entries are undefined after reset and only entries below the fill counts
// are ever read, so no clearing pass is needed.
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int unsigned FREE_ENTRIES = FreeEntriesDef,
  parameter int unsigned USED_ENTRIES = UsedEntriesDef,
  parameter int unsigned ADDR_BITS    = AddrBitsDef,
  parameter int unsigned JOB_BITS     = JobBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [1:0]            policy_i,
  input  logic [JOB_BITS-1:0]   job_id_i,
  input  logic [ADDR_BITS-1:0]  region_start_i,
  input  logic [ADDR_BITS-1:0]  size_words_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [StatusBits-1:0] status_o,
  output logic [ADDR_BITS-1:0]  granted_start_o,
  output logic [ADDR_BITS-1:0]  granted_size_o,
  output logic [JOB_BITS-1:0]   owner_job_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The sequencer decides, cycle by cycle, which datapath operation runs.
  vpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Tables, counters, comparators and the result register.
  vpa_datapath #(
    .FREE (FREE_ENTRIES),
    .USED (USED_ENTRIES),
    .AW   (ADDR_BITS),
    .JW   (JOB_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (func_i),
    .policy_i        (policy_i),
    .job_id_i        (job_id_i),
    .region_start_i  (region_start_i),
    .size_words_i    (size_words_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .granted_start_o (granted_start_o),
    .granted_size_o  (granted_size_o),
    .owner_job_o     (owner_job_o)
  );

endmodule

>>> hw/rtl/vpa_datapath.sv
// ----------------------------------------------------------------------------
// vpa_datapath: tables, scan registers and result register
// Holds the free-region and grant memories, the scan and shift counters, the
// fit and adjacency comparators, and the output register.
// ----------------------------------------------------------------------------
module vpa_datapath
  import vpa_pkg::*;
#(
  parameter int unsigned FREE = FreeEntriesDef,
  parameter int unsigned USED = UsedEntriesDef,
  parameter int unsigned AW   = AddrBitsDef,
  parameter int unsigned JW   = JobBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [1:0]            func_i,
  input  logic [1:0]            policy_i,
  input  logic [JW-1:0]         job_id_i,
  input  logic [AW-1:0]         region_start_i,
  input  logic [AW-1:0]         size_words_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [StatusBits-1:0] status_o,
  output logic [AW-1:0]         granted_start_o,
  output logic [AW-1:0]         granted_size_o,
  output logic [JW-1:0]         owner_job_o
);

  localparam int unsigned HCW = $clog2(FREE + 1);
  localparam int unsigned HIW = $clog2(FREE);
  localparam int unsigned GCW = $clog2(USED + 1);
  localparam int unsigned GIW = $clog2(USED);
  localparam int unsigned HDW = 2 * AW;
  localparam int unsigned GDW = 2 * AW + JW;

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW] ? {AW{1'b1}} : s[AW-1:0];
  endfunction

  logic [HDW-1:0] hmem [FREE];
  logic [GDW-1:0] gmem [USED];
  logic [HDW-1:0] hrd_q;
  logic [GDW-1:0] grd_q;

  logic [1:0]    func_q, pol_q;
  logic [JW-1:0] job_q;
  logic [AW-1:0] req_st_q, req_sz_q;
  logic [HCW-1:0] hcnt_q, h_idx_q, h_sh_q;
  logic [GCW-1:0] gcnt_q, g_idx_q;
  logic [GIW-1:0] g_pos_q;
  logic          best_v_q;
  logic [HIW-1:0] best_idx_q;
  logic [AW-1:0] best_st_q, best_sz_q;
  logic          g_found_q;
  logic [AW-1:0] g_st_q, g_ln_q;
  logic          p_v_q, s_v_q;
  logic [HIW-1:0] p_idx_q, s_idx_q;
  logic [AW-1:0] p_st_q, p_sz_q, s_sz_q;
  logic [AW-1:0] res_st_q, res_sz_q;
  logic          out_valid_q;
  logic [StatusBits-1:0] out_status_q;
  logic [AW-1:0] out_st_q, out_sz_q;
  logic [JW-1:0] out_job_q;

  logic [AW-1:0] hrd_st, hrd_sz, key_st, key_sz, grd_st, grd_sz;
  logic [JW-1:0] grd_own;
  logic [HCW-1:0] h_sh_p1, h_sh_m1;
  logic [GCW-1:0] g_idx_p1;
  logic [HIW-1:0] h_raddr, h_waddr;
  logic [GIW-1:0] g_raddr, g_waddr;
  logic          h_re, h_we, g_re, g_we;
  logic [HDW-1:0] h_wdata;
  logic [GDW-1:0] g_wdata;
  logic          take, bigger, smaller, pred_hit, succ_hit, out_free;
  logic [AW:0]   g_end;

  assign hrd_st  = hrd_q[HDW-1:AW];
  assign hrd_sz  = hrd_q[AW-1:0];
  assign grd_st  = grd_q[GDW-1:AW+JW];
  assign grd_sz  = grd_q[AW+JW-1:JW];
  assign grd_own = grd_q[JW-1:0];
  assign key_st  = (func_q == FUNC_LOAD) ? req_st_q : g_st_q;
  assign key_sz  = (func_q == FUNC_LOAD) ? req_sz_q : g_ln_q;
  assign h_sh_p1 = h_sh_q + HCW'(1);
  assign h_sh_m1 = h_sh_q - HCW'(1);
  assign g_idx_p1 = g_idx_q + GCW'(1);
  assign g_end   = {1'b0, g_st_q} + {1'b0, g_ln_q};
  assign out_free = !out_valid_q || !out_stall_i;

  // Fit comparison of the entry just read against the current pick.
  always_comb begin
    bigger  = (hrd_sz > best_sz_q) || ((hrd_sz == best_sz_q) && (hrd_st < best_st_q));
    smaller = (hrd_sz < best_sz_q) || ((hrd_sz == best_sz_q) && (hrd_st < best_st_q));
    if (pol_q == POL_WORST) begin
      take = !best_v_q || bigger;
    end else if (hrd_sz < req_sz_q) begin
      take = 1'b0;
    end else if (!best_v_q) begin
      take = 1'b1;
    end else if (pol_q == POL_BEST) begin
      take = smaller;
    end else begin
      take = hrd_st < best_st_q;
    end
  end

  // A hole ending at the released start comes first; otherwise it may start at its end.
  assign pred_hit = !p_v_q && (({1'b0, hrd_st} + {1'b0, hrd_sz}) == {1'b0, g_st_q});
  assign succ_hit = !pred_hit && !s_v_q && ({1'b0, hrd_st} == g_end);

  always_comb begin
    h_re    = 1'b0;
    h_raddr = h_idx_q[HIW-1:0];
    unique case (cmd_i.op)
      OP_H_READ_IDX:  h_re = 1'b1;
      OP_H_READ_SHDN: begin
        h_re    = 1'b1;
        h_raddr = h_sh_m1[HIW-1:0];
      end
      OP_H_READ_SHUP: begin
        h_re    = 1'b1;
        h_raddr = h_sh_p1[HIW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    h_we    = 1'b1;
    h_waddr = h_sh_q[HIW-1:0];
    h_wdata = hrd_q;
    unique case (cmd_i.op)
      OP_SHUP_WRITE, OP_SHDN_WRITE: ;
      OP_INS_WRITE: begin
        h_waddr = h_idx_q[HIW-1:0];
        h_wdata = {key_st, key_sz};
      end
      OP_SPLIT: begin
        h_waddr = best_idx_q;
        h_wdata = {best_st_q + req_sz_q, best_sz_q - req_sz_q};
      end
      OP_MERGE_BOTH: begin
        h_waddr = p_idx_q;
        h_wdata = {p_st_q, sat_add(sat_add(p_sz_q, g_ln_q), s_sz_q)};
      end
      OP_MERGE_PRED: begin
        h_waddr = p_idx_q;
        h_wdata = {p_st_q, sat_add(p_sz_q, g_ln_q)};
      end
      OP_MERGE_SUCC: begin
        h_waddr = s_idx_q;
        h_wdata = {g_st_q, sat_add(s_sz_q, g_ln_q)};
      end
      default: h_we = 1'b0;
    endcase
  end

  always_comb begin
    g_re    = (cmd_i.op == OP_G_READ) || (cmd_i.op == OP_G_READ_NEXT);
    g_raddr = (cmd_i.op == OP_G_READ_NEXT) ? g_idx_p1[GIW-1:0] : g_idx_q[GIW-1:0];
    g_we    = (cmd_i.op == OP_GRANT) || (cmd_i.op == OP_G_SHIFT_WRITE);
    g_waddr = (cmd_i.op == OP_GRANT) ? gcnt_q[GIW-1:0] : g_idx_q[GIW-1:0];
    g_wdata = (cmd_i.op == OP_GRANT) ? {best_st_q, req_sz_q, job_q} : grd_q;
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      hrd_q <= hmem[h_raddr];
    end
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      grd_q <= gmem[g_raddr];
    end
  end

  // Request and working registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        func_q   <= func_i;
        pol_q    <= policy_i;
        job_q    <= job_id_i;
        req_st_q <= region_start_i;
        req_sz_q <= size_words_i;
        res_st_q <= (func_i == FUNC_LOAD) ? region_start_i : '0;
        res_sz_q <= (func_i == FUNC_LOAD) ? size_words_i : '0;
      end
      OP_PICK_EVAL: begin
        if (take) begin
          best_idx_q <= h_idx_q[HIW-1:0];
          best_st_q  <= hrd_st;
          best_sz_q  <= hrd_sz;
        end
      end
      OP_GRANT: begin
        res_st_q <= best_st_q;
        res_sz_q <= req_sz_q;
      end
      OP_G_EVAL: begin
        if (grd_own == job_q) begin
          g_pos_q <= g_idx_q[GIW-1:0];
          g_st_q  <= grd_st;
          g_ln_q  <= grd_sz;
        end
      end
      OP_G_FOUND: begin
        res_st_q <= g_st_q;
        res_sz_q <= g_ln_q;
      end
      OP_ADJ_EVAL: begin
        if (pred_hit) begin
          p_idx_q <= h_idx_q[HIW-1:0];
          p_st_q  <= hrd_st;
          p_sz_q  <= hrd_sz;
        end
        if (succ_hit) begin
          s_idx_q <= h_idx_q[HIW-1:0];
          s_sz_q  <= hrd_sz;
        end
      end
      default: ;
    endcase
  end

  // Counters, flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q       <= '0;
      gcnt_q       <= '0;
      h_idx_q      <= '0;
      h_sh_q       <= '0;
      g_idx_q      <= '0;
      best_v_q     <= 1'b0;
      g_found_q    <= 1'b0;
      p_v_q        <= 1'b0;
      s_v_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_st_q     <= '0;
      out_sz_q     <= '0;
      out_job_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LATCH: begin
          h_idx_q   <= '0;
          g_idx_q   <= '0;
          best_v_q  <= 1'b0;
          g_found_q <= 1'b0;
          p_v_q     <= 1'b0;
          s_v_q     <= 1'b0;
        end
        OP_INS_EVAL: begin
          h_sh_q <= hcnt_q;
          if (hrd_st <= key_st) begin
            h_idx_q <= h_idx_q + HCW'(1);
          end
        end
        OP_SHUP_START: h_sh_q <= hcnt_q;
        OP_SHUP_WRITE: h_sh_q <= h_sh_m1;
        OP_INS_WRITE: begin
          hcnt_q  <= hcnt_q + HCW'(1);
          g_idx_q <= GCW'(g_pos_q);
        end
        OP_SHDN_WRITE: h_sh_q <= h_sh_p1;
        OP_H_DROP: begin
          hcnt_q  <= hcnt_q - HCW'(1);
          g_idx_q <= GCW'(g_pos_q);
        end
        OP_H_READ_IDX: ;
        OP_PICK_EVAL: begin
          h_idx_q <= h_idx_q + HCW'(1);
          if (take) begin
            best_v_q <= 1'b1;
          end
        end
        OP_GRANT: begin
          gcnt_q <= gcnt_q + GCW'(1);
          h_sh_q <= HCW'(best_idx_q);
        end
        OP_G_EVAL: begin
          g_idx_q <= g_idx_p1;
          if (grd_own == job_q) begin
            g_found_q <= 1'b1;
          end
        end
        OP_G_FOUND, OP_INS_START: h_idx_q <= '0;
        OP_ADJ_EVAL: begin
          h_idx_q <= h_idx_q + HCW'(1);
          if (pred_hit) begin
            p_v_q <= 1'b1;
          end
          if (succ_hit) begin
            s_v_q <= 1'b1;
          end
        end
        OP_MERGE_BOTH: h_sh_q <= HCW'(s_idx_q);
        OP_MERGE_PRED, OP_MERGE_SUCC: g_idx_q <= GCW'(g_pos_q);
        OP_G_SHIFT_WRITE: g_idx_q <= g_idx_p1;
        OP_G_DROP: gcnt_q <= gcnt_q - GCW'(1);
        OP_FINISH: begin
          out_valid_q  <= 1'b1;
          out_status_q <= cmd_i.code;
          out_st_q     <= (cmd_i.code == ST_OK) ? res_st_q : '0;
          out_sz_q     <= (cmd_i.code == ST_OK) ? res_sz_q : '0;
          out_job_q    <= job_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.func        = func_q;
    stat_o.size_zero   = (req_sz_q == '0);
    stat_o.h_full      = (hcnt_q == HCW'(FREE));
    stat_o.g_full      = (gcnt_q == GCW'(USED));
    stat_o.h_idx_end   = (h_idx_q == hcnt_q);
    stat_o.ins_le      = (hrd_st <= key_st);
    stat_o.h_sh_at_pos = (h_sh_q == h_idx_q);
    stat_o.h_rem_end   = ({1'b0, h_sh_q} + (HCW + 1)'(1)) >= {1'b0, hcnt_q};
    stat_o.pick_ok     = best_v_q && (best_sz_q >= req_sz_q);
    stat_o.exact       = (best_sz_q == req_sz_q);
    stat_o.g_idx_end   = (g_idx_q == gcnt_q);
    stat_o.g_rem_end   = ({1'b0, g_idx_q} + (GCW + 1)'(1)) >= {1'b0, gcnt_q};
    stat_o.g_found     = g_found_q;
    stat_o.pred_v      = p_v_q;
    stat_o.succ_v      = s_v_q;
    stat_o.out_free    = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_start_o = out_st_q;
  assign granted_size_o  = out_sz_q;
  assign owner_job_o     = out_job_q;

endmodule

>>> hw/rtl/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl: request sequencer
// Steps the datapath through the scans, shifts and writes of each request.
// ----------------------------------------------------------------------------
module vpa_ctrl
  import vpa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INS_CHK, S_INS_EV, S_SUP_CHK, S_SUP_WR, S_HRM_CHK, S_HRM_WR,
    S_PK_CHK, S_PK_EV, S_PK_END, S_SPLIT, S_GS_CHK, S_GS_EV, S_GS_END, S_AD_CHK,
    S_AD_EV, S_AD_END, S_GRM_CHK, S_GRM_WR, S_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [StatusBits-1:0] code_q, code_d;
  logic                  is_rel;

  assign is_rel     = (stat_i.func == FUNC_RELEASE);
  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o.code = code_q;

  always_comb begin
    state_d  = state_q;
    code_d   = code_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          code_d   = ST_OK;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (stat_i.func)
          FUNC_LOAD: begin
            if (stat_i.size_zero) begin
              code_d  = ST_ZERO_SZ;
              state_d = S_FIN;
            end else if (stat_i.h_full) begin
              code_d  = ST_FULL;
              state_d = S_FIN;
            end else begin
              state_d = S_INS_CHK;
            end
          end
          FUNC_ALLOC: begin
            if (stat_i.size_zero) begin
              code_d  = ST_ZERO_SZ;
              state_d = S_FIN;
            end else if (stat_i.g_full) begin
              code_d  = ST_FULL;
              state_d = S_FIN;
            end else begin
              state_d = S_PK_CHK;
            end
          end
          FUNC_RELEASE: state_d = S_GS_CHK;
          default:      state_d = S_FIN;
        endcase
      end
      S_INS_CHK: begin
        if (stat_i.h_idx_end) begin
          cmd_o.op = OP_SHUP_START;
          state_d  = S_SUP_CHK;
        end else begin
          cmd_o.op = OP_H_READ_IDX;
          state_d  = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd_o.op = OP_INS_EVAL;
        state_d  = stat_i.ins_le ? S_INS_CHK : S_SUP_CHK;
      end
      S_SUP_CHK: begin
        if (stat_i.h_sh_at_pos) begin
          cmd_o.op = OP_INS_WRITE;
          state_d  = is_rel ? S_GRM_CHK : S_FIN;
        end else begin
          cmd_o.op = OP_H_READ_SHDN;
          state_d  = S_SUP_WR;
        end
      end
      S_SUP_WR: begin
        cmd_o.op = OP_SHUP_WRITE;
        state_d  = S_SUP_CHK;
      end
      S_HRM_CHK: begin
        if (stat_i.h_rem_end) begin
          cmd_o.op = OP_H_DROP;
          state_d  = is_rel ? S_GRM_CHK : S_FIN;
        end else begin
          cmd_o.op = OP_H_READ_SHUP;
          state_d  = S_HRM_WR;
        end
      end
      S_HRM_WR: begin
        cmd_o.op = OP_SHDN_WRITE;
        state_d  = S_HRM_CHK;
      end
      S_PK_CHK: begin
        if (stat_i.h_idx_end) begin
          state_d = S_PK_END;
        end else begin
          cmd_o.op = OP_H_READ_IDX;
          state_d  = S_PK_EV;
        end
      end
      S_PK_EV: begin
        cmd_o.op = OP_PICK_EVAL;
        state_d  = S_PK_CHK;
      end
      S_PK_END: begin
        if (!stat_i.pick_ok) begin
          code_d  = ST_NO_FIT;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_GRANT;
          state_d  = stat_i.exact ? S_HRM_CHK : S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        state_d  = S_FIN;
      end
      S_GS_CHK: begin
        if (stat_i.g_idx_end) begin
          state_d = S_GS_END;
        end else begin
          cmd_o.op = OP_G_READ;
          state_d  = S_GS_EV;
        end
      end
      S_GS_EV: begin
        cmd_o.op = OP_G_EVAL;
        state_d  = S_GS_CHK;
      end
      S_GS_END: begin
        if (!stat_i.g_found) begin
          code_d  = ST_NO_JOB;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_G_FOUND;
          state_d  = S_AD_CHK;
        end
      end
      S_AD_CHK: begin
        if (stat_i.h_idx_end) begin
          state_d = S_AD_END;
        end else begin
          cmd_o.op = OP_H_READ_IDX;
          state_d  = S_AD_EV;
        end
      end
      S_AD_EV: begin
        cmd_o.op = OP_ADJ_EVAL;
        state_d  = S_AD_CHK;
      end
      S_AD_END: begin
        priority if (stat_i.pred_v && stat_i.succ_v) begin
          cmd_o.op = OP_MERGE_BOTH;
          state_d  = S_HRM_CHK;
        end else if (stat_i.pred_v) begin
          cmd_o.op = OP_MERGE_PRED;
          state_d  = S_GRM_CHK;
        end else if (stat_i.succ_v) begin
          cmd_o.op = OP_MERGE_SUCC;
          state_d  = S_GRM_CHK;
        end else if (stat_i.h_full) begin
          code_d  = ST_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_INS_START;
          state_d  = S_INS_CHK;
        end
      end
      S_GRM_CHK: begin
        if (stat_i.g_rem_end) begin
          cmd_o.op = OP_G_DROP;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_G_READ_NEXT;
          state_d  = S_GRM_WR;
        end
      end
      S_GRM_WR: begin
        cmd_o.op = OP_G_SHIFT_WRITE;
        state_d  = S_GRM_CHK;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

>>> hw/rtl/vpa_checker.sv
// ----------------------------------------------------------------------------
// vpa_checker: port-level checks of the partition allocator
// Watches the top-level ports and flags results or handshakes that cannot
// come from a correct allocator.
// ----------------------------------------------------------------------------
module vpa_checker
  import vpa_pkg::*;
#(
  parameter int unsigned ADDR_BITS = AddrBitsDef,
  parameter int unsigned JOB_BITS  = JobBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [StatusBits-1:0] status_o,
  input logic [ADDR_BITS-1:0]  granted_start_o,
  input logic [ADDR_BITS-1:0]  granted_size_o,
  input logic [JOB_BITS-1:0]   owner_job_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only defined status codes appear.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_ZERO_SZ))
    else $error("undefined status code");

  // A refused request reports no region.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (granted_start_o == '0) && (granted_size_o == '0))
    else $error("error result carries a region");

  // A zero-size refusal never reports a length.
  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ZERO_SZ) |-> (granted_size_o == '0))
    else $error("zero size result carries a length");

  // An accepted request keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted back to back");

endmodule

bind variable_partition_allocator vpa_checker #(
  .ADDR_BITS (ADDR_BITS),
  .JOB_BITS  (JOB_BITS)
) u_vpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .granted_start_o (granted_start_o),
  .granted_size_o  (granted_size_o),
  .owner_job_o     (owner_job_o)
);
